### rtl/flv_tsp_pkg.sv
// Package: shared types and constants of the FLV tag stream parser.
`timescale 1ns / 1ps

package flv_tsp_pkg;

  // Parser phase
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_TAGHEAD = 2'd1,
    PH_BODY    = 2'd2,
    PH_TRAILER = 2'd3
  } phase_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SIG  = 2'd1,
    ST_BAD_TYPE = 2'd2,
    ST_SIZE_ERR = 2'd3
  } status_t;

  localparam logic [23:0] FILE_HDR_LEN = 24'd13;
  localparam logic [23:0] TAG_HDR_LEN  = 24'd11;
  localparam logic [23:0] TRAILER_LEN  = 24'd4;
  localparam logic [23:0] SIG_LEN      = 24'd3;
  localparam logic [23:0] LEN_LAST     = 24'd3;   // last body-length byte
  localparam logic [23:0] TIME_LAST    = 24'd6;   // last timestamp byte
  localparam logic [31:0] TAG_HDR_LEN32 = 32'd11;

  localparam logic [7:0] TYPE_AUDIO = 8'h08;
  localparam logic [7:0] TYPE_VIDEO = 8'h09;
  localparam logic [7:0] TYPE_META  = 8'h12;

  localparam logic [23:0] TS_MAX = 24'hFF_FFFF;

  // One result request
  typedef struct packed {
    logic [23:0] max_timestamp;
    logic [23:0] min_timestamp;
    logic [31:0] tag_offset;
    logic [23:0] tag_timestamp;
    logic [23:0] body_length;
    logic [7:0]  tag_type;
    status_t     status;
  } result_t;

  // "FLV" signature byte by position
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = 8'h46;
      2'd1:    val = 8'h4C;
      2'd2:    val = 8'h56;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

### rtl/flv_tsp_core.sv
// Parser core: per-byte state update and result generation.
`timescale 1ns / 1ps

module flv_tsp_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  byte_fire,
  input  logic [7:0]            data_byte,
  input  logic                  file_start,
  output logic                  res_valid,
  output flv_tsp_pkg::result_t  res
);

  flv_tsp_pkg::phase_t phase_r, phase_nxt, eff_phase;
  logic [23:0] cnt_r, cnt_nxt, eff_cnt, cnt_inc;
  logic [7:0]  type_r, type_nxt, eff_type;
  logic [23:0] len_r, len_nxt, eff_len;
  logic [23:0] time_r, time_nxt, eff_time;
  logic [31:0] trl_r, trl_nxt, eff_trl, trl_new;
  logic [31:0] off_r, off_nxt, eff_off;
  logic [31:0] start_r, start_nxt, eff_start;
  logic [23:0] low_r, low_nxt, eff_low, low_upd;
  logic [23:0] high_r, high_nxt, eff_high, high_upd;
  logic        halted_r, halted_nxt, eff_halted;

  logic sig_bad, type_bad, trl_done, size_bad;

  // file_start restarts from the reset state before this byte is parsed
  always_comb begin
    eff_phase  = file_start ? flv_tsp_pkg::PH_HEADER : phase_r;
    eff_cnt    = file_start ? 24'd0 : cnt_r;
    eff_type   = file_start ? 8'd0 : type_r;
    eff_len    = file_start ? 24'd0 : len_r;
    eff_time   = file_start ? 24'd0 : time_r;
    eff_trl    = file_start ? 32'd0 : trl_r;
    eff_off    = file_start ? 32'd0 : off_r;
    eff_start  = file_start ? 32'd0 : start_r;
    eff_low    = file_start ? flv_tsp_pkg::TS_MAX : low_r;
    eff_high   = file_start ? 24'd0 : high_r;
    eff_halted = file_start ? 1'b0 : halted_r;
  end

  assign cnt_inc  = eff_cnt + 24'd1;
  assign trl_new  = {eff_trl[23:0], data_byte};
  assign low_upd  = (eff_time < eff_low) ? eff_time : eff_low;
  assign high_upd = (eff_time > eff_high) ? eff_time : eff_high;

  assign sig_bad  = (eff_phase == flv_tsp_pkg::PH_HEADER) &&
                    (eff_cnt < flv_tsp_pkg::SIG_LEN) &&
                    (data_byte != flv_tsp_pkg::sig_byte(eff_cnt[1:0]));
  assign type_bad = (eff_phase == flv_tsp_pkg::PH_TAGHEAD) && (eff_cnt == 24'd0) &&
                    (data_byte != flv_tsp_pkg::TYPE_AUDIO) &&
                    (data_byte != flv_tsp_pkg::TYPE_VIDEO) &&
                    (data_byte != flv_tsp_pkg::TYPE_META);
  assign trl_done = (eff_phase == flv_tsp_pkg::PH_TRAILER) &&
                    (cnt_inc >= flv_tsp_pkg::TRAILER_LEN);
  assign size_bad = trl_new != ({8'd0, eff_len} + flv_tsp_pkg::TAG_HDR_LEN32);

  // Next state
  always_comb begin
    phase_nxt  = eff_phase;
    cnt_nxt    = eff_cnt;
    type_nxt   = eff_type;
    len_nxt    = eff_len;
    time_nxt   = eff_time;
    trl_nxt    = eff_trl;
    off_nxt    = eff_off;
    start_nxt  = eff_start;
    low_nxt    = eff_low;
    high_nxt   = eff_high;
    halted_nxt = eff_halted;
    if (!eff_halted) begin
      off_nxt = eff_off + 32'd1;
      case (eff_phase)
        flv_tsp_pkg::PH_HEADER: begin
          if (sig_bad) begin
            halted_nxt = 1'b1;
          end else if (cnt_inc >= flv_tsp_pkg::FILE_HDR_LEN) begin
            phase_nxt = flv_tsp_pkg::PH_TAGHEAD;
            cnt_nxt   = 24'd0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        flv_tsp_pkg::PH_TAGHEAD: begin
          if (type_bad) begin
            halted_nxt = 1'b1;
          end else begin
            if (eff_cnt == 24'd0) begin
              start_nxt = eff_off;
              type_nxt  = data_byte;
              len_nxt   = 24'd0;
              time_nxt  = 24'd0;
            end else if (eff_cnt <= flv_tsp_pkg::LEN_LAST) begin
              len_nxt = {eff_len[15:0], data_byte};
            end else if (eff_cnt <= flv_tsp_pkg::TIME_LAST) begin
              time_nxt = {eff_time[15:0], data_byte};
            end
            if (cnt_inc >= flv_tsp_pkg::TAG_HDR_LEN) begin
              cnt_nxt   = 24'd0;
              trl_nxt   = 32'd0;
              phase_nxt = (eff_len == 24'd0) ? flv_tsp_pkg::PH_TRAILER
                                             : flv_tsp_pkg::PH_BODY;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
        end
        flv_tsp_pkg::PH_BODY: begin
          if (cnt_inc >= eff_len) begin
            cnt_nxt   = 24'd0;
            trl_nxt   = 32'd0;
            phase_nxt = flv_tsp_pkg::PH_TRAILER;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        flv_tsp_pkg::PH_TRAILER: begin
          trl_nxt = trl_new;
          if (trl_done) begin
            cnt_nxt   = 24'd0;
            phase_nxt = flv_tsp_pkg::PH_TAGHEAD;
            if (size_bad) begin
              halted_nxt = 1'b1;
            end else begin
              low_nxt  = low_upd;
              high_nxt = high_upd;
            end
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        default: begin
          phase_nxt = flv_tsp_pkg::PH_HEADER;
        end
      endcase
    end
  end

  // Result outputs
  always_comb begin
    res_valid         = 1'b0;
    res.tag_type      = 8'd0;
    res.body_length   = 24'd0;
    res.tag_timestamp = 24'd0;
    res.tag_offset    = eff_off;
    res.status        = flv_tsp_pkg::ST_OK;
    res.min_timestamp = eff_low;
    res.max_timestamp = eff_high;
    if (byte_fire && !eff_halted) begin
      if (sig_bad) begin
        res_valid  = 1'b1;
        res.status = flv_tsp_pkg::ST_BAD_SIG;
      end else if (type_bad) begin
        res_valid    = 1'b1;
        res.tag_type = data_byte;
        res.status   = flv_tsp_pkg::ST_BAD_TYPE;
      end else if (trl_done) begin
        res_valid         = 1'b1;
        res.tag_type      = eff_type;
        res.body_length   = eff_len;
        res.tag_timestamp = eff_time;
        res.tag_offset    = eff_start;
        if (size_bad) begin
          res.status = flv_tsp_pkg::ST_SIZE_ERR;
        end else begin
          res.min_timestamp = low_upd;
          res.max_timestamp = high_upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= flv_tsp_pkg::PH_HEADER;
      cnt_r    <= 24'd0;
      type_r   <= 8'd0;
      len_r    <= 24'd0;
      time_r   <= 24'd0;
      trl_r    <= 32'd0;
      off_r    <= 32'd0;
      start_r  <= 32'd0;
      low_r    <= flv_tsp_pkg::TS_MAX;
      high_r   <= 24'd0;
      halted_r <= 1'b0;
    end else if (byte_fire) begin
      phase_r  <= phase_nxt;
      cnt_r    <= cnt_nxt;
      type_r   <= type_nxt;
      len_r    <= len_nxt;
      time_r   <= time_nxt;
      trl_r    <= trl_nxt;
      off_r    <= off_nxt;
      start_r  <= start_nxt;
      low_r    <= low_nxt;
      high_r   <= high_nxt;
      halted_r <= halted_nxt;
    end
  end

`ifndef SYNTHESIS
  // Running extremes stay ordered once a good tag has been seen
  a_minmax: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == flv_tsp_pkg::ST_OK) |->
      (res.min_timestamp <= res.max_timestamp))
    else $error("min timestamp above max on good tag");

  // A halted parser only restarts on file_start
  a_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (halted_r && byte_fire && !file_start) |-> !res_valid)
    else $error("result while halted");

  // Error results always halt the parser
  a_err_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != flv_tsp_pkg::ST_OK) |=> halted_r)
    else $error("error result without halt");
`endif

endmodule

### rtl/flv_tsp_outbuf.sv
// Output register with skid stage for result requests.
`timescale 1ns / 1ps

module flv_tsp_outbuf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  flv_tsp_pkg::result_t  push_data,
  output logic                  push_ready,
  output logic                  out_valid,
  output flv_tsp_pkg::result_t  out_data,
  input  logic                  out_ready
);

  logic                 out_valid_r, skid_valid_r;
  flv_tsp_pkg::result_t out_data_r, skid_data_r;
  logic                 load;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign load       = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds data while output register empty");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !skid_valid_r)
    else $error("push into full buffer");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> out_valid_r)
    else $error("skid entry lost");
`endif

endmodule

### rtl/flv_tag_stream_parser_top.sv
// Top level of the FLV tag stream parser.
`timescale 1ns / 1ps
// Usage:
//   Input stream: one request per FLV file byte, data byte in in_tdata,
//   in_tuser high on byte 0 of a new file (restarts the parser first).
//   The "FLV" signature is checked, the 13-byte file header skipped, then
//   each tag header, body and 4-byte previous-tag-size is walked.
//   Output stream: one result request after the last trailer byte of every
//   tag, or at the byte that caused an error (bad signature, bad type,
//   size mismatch). After an error the parser drops bytes until in_tuser.
// Throughput: one byte per cycle, sustained, while results are taken.
// Result path: the single-pass byte logic sits between the input handshake
//   and a two-entry output register/skid buffer; a result is registered in
//   the output register, or in the skid entry while out_tready is low.
// Stalls: with out_tready low the buffer absorbs one more result, then
//   in_tready drops until the output register drains.
// Reset: rst_n synchronous, active low; parser returns to file header
//   phase, min timestamp 0xFFFFFF, max 0, buffer empty.

module flv_tag_stream_parser_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic [0:0]   in_tuser,   // [0] file_start
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] tag_type, [31:8] body_length, [55:32] tag_timestamp,
  // [87:56] tag_offset, [111:88] min_timestamp, [135:112] max_timestamp
  output logic [135:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] status
);

  logic                 in_fire;
  logic                 res_valid;
  flv_tsp_pkg::result_t res;
  flv_tsp_pkg::result_t out_res;

  assign in_fire = in_tvalid && in_tready;

  flv_tsp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_fire  (in_fire),
    .data_byte  (in_tdata),
    .file_start (in_tuser[0]),
    .res_valid  (res_valid),
    .res        (res)
  );

  flv_tsp_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_data   (out_res),
    .out_ready  (out_tready)
  );

  assign out_tdata = {out_res.max_timestamp, out_res.min_timestamp, out_res.tag_offset,
                      out_res.tag_timestamp, out_res.body_length, out_res.tag_type};
  assign out_tuser = out_res.status;

endmodule

### tb/sv/flv_tag_stream_parser_top_tb.sv
// Testbench for flv_tag_stream_parser_top: FLV byte streams checked against an in-bench parser.
`timescale 1ns / 1ps

module flv_tag_stream_parser_top_tb;
  import flv_tsp_pkg::*;

  // "FLV" signature, first byte in the top bits
  localparam logic [23:0] FLV_MAGIC = 24'h46_4C_56;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;    // [7:0] data_byte
  logic [0:0]   in_tuser;    // [0] file_start
  logic         out_tvalid;
  logic         out_tready;
  // [7:0] tag_type, [31:8] body_length, [55:32] tag_timestamp,
  // [87:56] tag_offset, [111:88] min_timestamp, [135:112] max_timestamp
  logic [135:0] out_tdata;
  logic [1:0]   out_tuser;   // [1:0] status

  flv_tag_stream_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Tag results predicted but not yet seen on the output, oldest first
  result_t tag_results[$];
  int      n_fail = 0;
  int      bytes_parsed = 0;   // bytes the parser acts on (halted drops excluded)

  // Idle / stall knobs shared by the sender, the receiver and the tests
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;
  int rx_hold_len = 0;        // receiver hold-off, counted down by the receiver

  // ---------------------------------------------------------------------------
  // Parser shadow: walks the same byte stream as the block
  // ---------------------------------------------------------------------------
  phase_t      parser_phase;
  logic [23:0] parser_count;
  logic [7:0]  parser_type;
  logic [23:0] parser_len;
  logic [23:0] parser_ts;
  logic [31:0] parser_trailer;
  logic [31:0] parser_offset;
  logic [31:0] parser_tag_off;
  logic [23:0] parser_min_ts;
  logic [23:0] parser_max_ts;
  logic        parser_halted;

  task automatic parser_clear();
    parser_phase   = PH_HEADER;
    parser_count   = '0;
    parser_type    = '0;
    parser_len     = '0;
    parser_ts      = '0;
    parser_trailer = '0;
    parser_offset  = '0;
    parser_tag_off = '0;
    parser_min_ts  = TS_MAX;
    parser_max_ts  = '0;
    parser_halted  = 1'b0;
  endtask

  function automatic result_t make_result(input logic [7:0] kind, input logic [23:0] len,
                                          input logic [23:0] ts, input logic [31:0] off,
                                          input status_t st);
    result_t r;
    r.tag_type      = kind;
    r.body_length   = len;
    r.tag_timestamp = ts;
    r.tag_offset    = off;
    r.status        = st;
    r.min_timestamp = parser_min_ts;
    r.max_timestamp = parser_max_ts;
    return r;
  endfunction

  // Advance the shadow parser by one accepted byte; queue any tag result
  task automatic parser_take_byte(input logic [7:0] b, input logic fs);
    if (fs)
      parser_clear();
    if (parser_halted)
      return;
    case (parser_phase)
      PH_HEADER: begin
        if (parser_count < SIG_LEN && b != FLV_MAGIC[8*(2 - parser_count[1:0]) +: 8]) begin
          tag_results.push_back(make_result(8'h00, '0, '0, parser_offset, ST_BAD_SIG));
          parser_halted = 1'b1;
        end else begin
          parser_count = parser_count + 1'b1;
          if (parser_count >= FILE_HDR_LEN) begin
            parser_phase = PH_TAGHEAD;
            parser_count = '0;
          end
        end
      end
      PH_TAGHEAD: begin
        if (parser_count == 0 && b != TYPE_AUDIO && b != TYPE_VIDEO && b != TYPE_META) begin
          tag_results.push_back(make_result(b, '0, '0, parser_offset, ST_BAD_TYPE));
          parser_halted = 1'b1;
        end else begin
          if (parser_count == 0) begin
            parser_tag_off = parser_offset;
            parser_type    = b;
            parser_len     = '0;
            parser_ts      = '0;
          end else if (parser_count <= LEN_LAST) begin
            parser_len = {parser_len[15:0], b};
          end else if (parser_count <= TIME_LAST) begin
            parser_ts = {parser_ts[15:0], b};
          end
          parser_count = parser_count + 1'b1;
          if (parser_count >= TAG_HDR_LEN) begin
            parser_count   = '0;
            parser_trailer = '0;
            if (parser_len == 0)
              parser_phase = PH_TRAILER;
            else
              parser_phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        parser_count = parser_count + 1'b1;
        if (parser_count >= parser_len) begin
          parser_count   = '0;
          parser_trailer = '0;
          parser_phase   = PH_TRAILER;
        end
      end
      default: begin
        parser_trailer = {parser_trailer[23:0], b};
        parser_count   = parser_count + 1'b1;
        if (parser_count >= TRAILER_LEN) begin
          if (parser_trailer != {8'h00, parser_len} + TAG_HDR_LEN32) begin
            // extremes stay as they were on a mismatch
            tag_results.push_back(make_result(parser_type, parser_len, parser_ts,
                                              parser_tag_off, ST_SIZE_ERR));
            parser_halted = 1'b1;
          end else begin
            if (parser_ts < parser_min_ts) parser_min_ts = parser_ts;
            if (parser_ts > parser_max_ts) parser_max_ts = parser_ts;
            tag_results.push_back(make_result(parser_type, parser_len, parser_ts,
                                              parser_tag_off, ST_OK));
          end
          parser_count = '0;
          parser_phase = PH_TAGHEAD;
        end
      end
    endcase
    parser_offset = parser_offset + 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one byte request; entered and left at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic fs);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (fs || !parser_halted)
      bytes_parsed++;
    parser_take_byte(b, fs);
    @(negedge clk);
  endtask

  // 13-byte file header; bad_pos 0..2 corrupts that signature byte, 3 keeps it clean
  task automatic put_file_header(input int bad_pos, input logic fs);
    logic [7:0] v;
    int i;
    for (i = 0; i < FILE_HDR_LEN; i++) begin
      if (i < 3) begin
        v = FLV_MAGIC[8*(2 - i) +: 8];
        if (i == bad_pos)
          while (v == FLV_MAGIC[8*(2 - i) +: 8]) v = 8'($urandom_range(0, 255));
      end else begin
        v = 8'($urandom_range(0, 255));
      end
      put_byte(v, fs && i == 0);
    end
  endtask

  // Whole tag: header, random body, trailer of len + 11 + skew
  task automatic put_tag(input logic [7:0] kind, input logic [23:0] len,
                         input logic [23:0] ts, input logic [31:0] skew);
    logic [31:0] tsize;
    int i;
    tsize = {8'h00, len} + TAG_HDR_LEN32 + skew;
    put_byte(kind, 1'b0);
    for (i = 2; i >= 0; i--) put_byte(len[8*i +: 8], 1'b0);
    for (i = 2; i >= 0; i--) put_byte(ts[8*i +: 8], 1'b0);
    repeat (4) put_byte(8'($urandom_range(0, 255)), 1'b0);   // ts extension + stream id
    for (i = 0; i < len; i++) put_byte(8'($urandom_range(0, 255)), 1'b0);
    for (i = 3; i >= 0; i--) put_byte(tsize[8*i +: 8], 1'b0);
  endtask

  // Stop offering and let every predicted result come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tag_results.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : rx_stall
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_len > 0) begin
        rx_hold_len--;
        out_tready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_tready <= 1'b0;
      end else begin
        stall = rx_idle_en ? pick_gap() : 0;
        out_tready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result check against the oldest prediction
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_fail++;
    end
  endfunction

  result_t want_r;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (tag_results.size() == 0) begin
        $error("result with no tag pending: tdata 0x%0h status %0d", out_tdata, out_tuser);
        n_fail++;
      end else begin
        want_r = tag_results.pop_front();
        check_field("tag_type",      32'(want_r.tag_type),      32'(out_tdata[7:0]));
        check_field("body_length",   32'(want_r.body_length),   32'(out_tdata[31:8]));
        check_field("tag_timestamp", 32'(want_r.tag_timestamp), 32'(out_tdata[55:32]));
        check_field("tag_offset",    want_r.tag_offset,         out_tdata[87:56]);
        check_field("min_timestamp", 32'(want_r.min_timestamp), 32'(out_tdata[111:88]));
        check_field("max_timestamp", 32'(want_r.max_timestamp), 32'(out_tdata[135:112]));
        check_field("status",        32'(want_r.status),        32'(out_tuser));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // No file_start at all: the parser runs from its reset state
  task automatic test_start_from_reset();
    put_file_header(3, 1'b0);
    put_tag(TYPE_AUDIO, 24'd0, 24'd0, 32'd0);
  endtask

  // Bad signature at each of the three leading bytes; the rest is dropped
  task automatic test_bad_signature();
    int k;
    for (k = 0; k < 3; k++) begin
      put_file_header(k, 1'b1);
      put_tag(TYPE_VIDEO, 24'd1, 24'h00_0010, 32'd0);   // ignored while halted
    end
  endtask

  // All three tag kinds, timestamp extremes, zero and short bodies, bad type bytes
  task automatic test_tag_kinds();
    put_file_header(3, 1'b1);
    put_tag(TYPE_AUDIO, 24'd0, TS_MAX, 32'd0);
    put_tag(TYPE_VIDEO, 24'd1, 24'd0, 32'd0);
    put_tag(TYPE_META,  24'd3, 24'h12_3456, 32'd0);
    put_tag(8'h00, 24'd0, 24'd0, 32'd0);             // bad type, then halted
    put_file_header(3, 1'b1);
    put_tag(TYPE_VIDEO, 24'd2, 24'h80_0001, 32'd0);
    put_tag(8'hFF, 24'd0, 24'd0, 32'd0);
  endtask

  // Trailer mismatch: on the first tag of a file the extremes still read their reset values
  task automatic test_size_mismatch();
    put_file_header(3, 1'b1);
    put_tag(TYPE_AUDIO, 24'd0, 24'h00_0400, 32'd1);
    put_file_header(3, 1'b1);
    put_tag(TYPE_META, 24'd4, 24'h7F_FFFF, 32'd0);
    put_tag(TYPE_VIDEO, 24'd0, 24'h00_0005, 32'hFFFF_FFF5);   // trailer reads zero
    put_file_header(3, 1'b1);
    put_tag(TYPE_AUDIO, 24'd2, 24'd9, 32'hFFFF_FFF2);         // trailer all ones
  endtask

  // One long body whose length needs the middle length byte
  task automatic test_long_body();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    put_file_header(3, 1'b1);
    put_tag(TYPE_VIDEO, 24'h00_0100, 24'h00_3000, 32'd0);
    put_tag(TYPE_AUDIO, 24'd0, 24'h00_2000, 32'd0);
    wait_drained();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Receiver holds off while short tags keep coming: buffer fills and input stalls
  task automatic test_backpressure();
    int k;
    tx_idle_en  = 1'b0;
    rx_hold_len = 300;
    put_file_header(3, 1'b1);
    for (k = 0; k < 6; k++)
      put_tag(TYPE_AUDIO + k[0], 24'd0, 24'($urandom_range(0, 24'hFF_FFFF)), 32'd0);
    wait_drained();
    tx_idle_en = 1'b1;
  endtask

  // Random files: mostly well-formed tags with random content, some broken ones
  task automatic test_random_files(input int n_bytes);
    int first;
    int r;
    int k;
    int n_tags;
    logic [7:0]  kind;
    logic [23:0] len;
    logic [23:0] ts;
    logic [23:0] ts_base;
    logic [31:0] skew;
    first = bytes_parsed;
    while (bytes_parsed - first < n_bytes) begin
      // idle mix per file, including stretches with no idling on either side
      r = $urandom_range(0, 9);
      tx_idle_en = (r != 0 && r != 1);
      rx_idle_en = (r != 0 && r != 2);
      if ($urandom_range(0, 99) < 4) begin
        put_file_header($urandom_range(0, 2), 1'b1);
      end else begin
        put_file_header(3, 1'b1);
        ts_base = 24'($urandom_range(0, 24'hFF_FFFF));
        n_tags  = $urandom_range(1, 6);
        for (k = 0; k < n_tags && !parser_halted; k++) begin
          if ($urandom_range(0, 99) < 5)
            repeat ($urandom_range(1, 8)) put_byte(8'($urandom_range(0, 255)), 1'b0);
          r = $urandom_range(0, 99);
          if (r < 92) begin
            case ($urandom_range(0, 2))
              0:       kind = TYPE_AUDIO;
              1:       kind = TYPE_VIDEO;
              default: kind = TYPE_META;
            endcase
          end else begin
            kind = 8'($urandom_range(0, 255));
            while (kind == TYPE_AUDIO || kind == TYPE_VIDEO || kind == TYPE_META)
              kind = 8'($urandom_range(0, 255));
          end
          r = $urandom_range(0, 99);
          if (r < 70)      len = 24'($urandom_range(0, 4));
          else if (r < 95) len = 24'($urandom_range(5, 20));
          else             len = 24'($urandom_range(21, 300));
          r = $urandom_range(0, 99);
          if (r < 40)      ts = 24'($urandom_range(0, 24'hFF_FFFF));
          else if (r < 80) ts = ts_base + 24'($urandom_range(0, 64)) - 24'd32;
          else             ts = r[0] ? TS_MAX : 24'd0;
          r = $urandom_range(0, 99);
          if (r < 92)      skew = 32'd0;
          else if (r < 96) skew = r[0] ? 32'd1 : 32'hFFFF_FFFF;
          else             skew = {$urandom} | 32'd1;
          put_tag(kind, len, ts, skew);
        end
      end
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    parser_clear();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_start_from_reset();
    test_bad_signature();
    test_tag_kinds();
    test_size_mismatch();
    wait_drained();            // sender pause until every result is back
    test_long_body();
    test_backpressure();
    test_random_files(150);

    wait_drained();
    repeat (8) @(posedge clk);
    if (n_fail == 0 && tag_results.size() == 0)
      $display("flv_tag_stream_parser_top_tb passed");
    else
      $display("flv_tag_stream_parser_top_tb failed");
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #3_000_000;
    $display("flv_tag_stream_parser_top_tb failed");
    $finish;
  end

endmodule

### filelist.f
rtl/flv_tsp_pkg.sv
rtl/flv_tsp_core.sv
rtl/flv_tsp_outbuf.sv
rtl/flv_tag_stream_parser_top.sv
tb/sv/flv_tag_stream_parser_top_tb.sv
